FILE: src/geohash_codec_assert.svh
// Assertion macros for the geohash codec; gh_ctrl includes them.
// Depends on nothing; included by modules that check their own logic.
`ifndef GEOHASH_CODEC_ASSERT_SVH
`define GEOHASH_CODEC_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GH_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GH_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: src/gh_pkg.sv
// Package for the geohash codec: word types, function codes, states, tables.
// Depends on nothing.
package gh_pkg;
  localparam int MaxChars = 12;
  localparam int CntW = 4;

  localparam logic [1:0] FuncEncode = 2'd0;
  localparam logic [1:0] FuncDecode = 2'd1;
  localparam logic [1:0] FuncNeighbor = 2'd2;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBadChar = 2'd1;
  localparam logic [1:0] StatusTooLong = 2'd2;

  // Neighbor directions, clockwise from north; self and above repeat the hash.
  localparam logic [3:0] DirN = 4'd0;
  localparam logic [3:0] DirNE = 4'd1;
  localparam logic [3:0] DirE = 4'd2;
  localparam logic [3:0] DirSE = 4'd3;
  localparam logic [3:0] DirS = 4'd4;
  localparam logic [3:0] DirSW = 4'd5;
  localparam logic [3:0] DirW = 4'd6;
  localparam logic [3:0] DirNW = 4'd7;
  localparam logic [3:0] DirSelf = 4'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic signed [31:0] latitude_in;
    logic signed [31:0] longitude_in;
    logic [3:0]  precision;
    logic [7:0]  hash_char_in;
    logic        last_char_in;
    logic [3:0]  neighbor_dir;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  hash_char_out;
    logic        last_out;
    logic signed [31:0] center_lat;
    logic signed [31:0] center_lon;
    logic [31:0] lat_halfwidth;
    logic [31:0] lon_halfwidth;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ABSORB, ST_CENTER, ST_SETUP, ST_BISECT, ST_EMIT, ST_STORED,
    ST_READ, ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;      // capture the input word
    logic absorb_step;  // one decode bisection step
    logic absorb_store; // store the symbol and count it
    logic set_err;      // record error code
    logic [1:0] err;
    logic calc_center;  // compute center and half widths
    logic enc_init;     // load encode target and reset encode bounds
    logic enc_step;     // one encode bisection step
    logic clear_dec;    // return decode state to reset
    logic out_load;     // load output register
    logic out_stored;   // output from stored symbol
    logic out_decode;   // output decode result
    logic out_empty;    // neighbor of empty hash
    logic out_last;
    logic rd_next;      // advance store read
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       sym_valid;
    logic       last_char;
    logic       full;
    logic       err_free;
    logic       self_dir;
    logic [CntW-1:0] chars;
    logic [CntW-1:0] precision;
  } stat_t;

  function automatic logic [7:0] sym_char(input logic [4:0] s);
    logic [7:0] c;
    case (s)
      5'd0: c = "0"; 5'd1: c = "1"; 5'd2: c = "2"; 5'd3: c = "3";
      5'd4: c = "4"; 5'd5: c = "5"; 5'd6: c = "6"; 5'd7: c = "7";
      5'd8: c = "8"; 5'd9: c = "9"; 5'd10: c = "b"; 5'd11: c = "c";
      5'd12: c = "d"; 5'd13: c = "e"; 5'd14: c = "f"; 5'd15: c = "g";
      5'd16: c = "h"; 5'd17: c = "j"; 5'd18: c = "k"; 5'd19: c = "m";
      5'd20: c = "n"; 5'd21: c = "p"; 5'd22: c = "q"; 5'd23: c = "r";
      5'd24: c = "s"; 5'd25: c = "t"; 5'd26: c = "u"; 5'd27: c = "v";
      5'd28: c = "w"; 5'd29: c = "x"; 5'd30: c = "y"; default: c = "z";
    endcase
    return c;
  endfunction

  // Symbol of an ASCII character, bit 5 set when it is not in the alphabet.
  function automatic logic [5:0] char_sym(input logic [7:0] ch);
    logic [7:0] c;
    logic [5:0] s;
    c = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
    s = 6'h20;
    case (c)
      "0": s = 6'd0; "1": s = 6'd1; "2": s = 6'd2; "3": s = 6'd3;
      "4": s = 6'd4; "5": s = 6'd5; "6": s = 6'd6; "7": s = 6'd7;
      "8": s = 6'd8; "9": s = 6'd9; "b": s = 6'd10; "c": s = 6'd11;
      "d": s = 6'd12; "e": s = 6'd13; "f": s = 6'd14; "g": s = 6'd15;
      "h": s = 6'd16; "j": s = 6'd17; "k": s = 6'd18; "m": s = 6'd19;
      "n": s = 6'd20; "p": s = 6'd21; "q": s = 6'd22; "r": s = 6'd23;
      "s": s = 6'd24; "t": s = 6'd25; "u": s = 6'd26; "v": s = 6'd27;
      "w": s = 6'd28; "x": s = 6'd29; "y": s = 6'd30; "z": s = 6'd31;
      default: s = 6'h20;
    endcase
    return s;
  endfunction
endpackage

FILE: src/gh_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
module gh_ram #(
  parameter int Width = 5,
  parameter int Depth = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/gh_datapath.sv
// Datapath of the geohash codec: bounds, bisection unit, symbol store, output word.
// Depends on gh_pkg and gh_ram.
module gh_datapath import gh_pkg::*; #(
  parameter int CoordBits = 32,
  parameter int MaxCh = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_word_t out_word
);
  localparam int BW = CoordBits + 2;
  localparam int AW = (MaxCh > 1) ? $clog2(MaxCh) : 1;
  localparam logic signed [BW-1:0] Half = BW'(1) <<< (CoordBits - 1);

  in_word_t inr;
  logic signed [BW-1:0] lat_low, lat_high, lon_low, lon_high;
  logic signed [BW-1:0] e_lat_lo, e_lat_hi, e_lon_lo, e_lon_hi, t_lat, t_lon;
  logic signed [BW-1:0] clat, clon, hlat, hlon;
  logic axis_is_lon, e_on_lon;
  logic [CntW-1:0] chars_seen;
  logic [1:0] error_seen;
  logic [2:0] bit_idx;
  logic [4:0] sym_acc;
  logic [CntW-1:0] rd_ptr;
  logic [4:0] rd_data;
  logic [5:0] sym;

  assign sym = char_sym(inr.hash_char_in);

  // Floor of half a sum: arithmetic shift.
  function automatic logic signed [BW-1:0] mid(input logic signed [BW-1:0] a,
                                               input logic signed [BW-1:0] b);
    logic signed [BW:0] s;
    s = {a[BW-1], a} + {b[BW-1], b};
    return s[BW:1];
  endfunction

  function automatic logic signed [BW-1:0] sat(input logic signed [BW-1:0] v);
    if (v > Half) return Half;
    if (v < -Half) return -Half;
    return v;
  endfunction

  logic signed [BW-1:0] dm_lon, dm_lat, em_lon, em_lat, dbl_lat, dbl_lon;
  logic dec_bit;
  logic [3:0] dir;
  assign dm_lon = mid(lon_low, lon_high);
  assign dm_lat = mid(lat_low, lat_high);
  assign em_lon = mid(e_lon_lo, e_lon_hi);
  assign em_lat = mid(e_lat_lo, e_lat_hi);
  assign dec_bit = sym[3'd4 - bit_idx];
  assign dir = inr.neighbor_dir;
  assign dbl_lat = hlat <<< 1;
  assign dbl_lon = hlon <<< 1;

  // Neighbor target offsets by direction.
  logic signed [BW-1:0] n_lat, n_lon;
  always_comb begin
    n_lat = clat;
    n_lon = clon;
    if (dir == DirN || dir == DirNE || dir == DirNW) n_lat = clat + dbl_lat;
    if (dir == DirSE || dir == DirS || dir == DirSW) n_lat = clat - dbl_lat;
    if (dir == DirNE || dir == DirE || dir == DirSE) n_lon = clon + dbl_lon;
    if (dir == DirSW || dir == DirW || dir == DirNW) n_lon = clon - dbl_lon;
  end

  // Symbol store.
  gh_ram #(.Width(5), .Depth(MaxCh)) u_store (
    .clk(clk), .we(cmd.absorb_store), .waddr(chars_seen[AW-1:0]),
    .wdata(sym[4:0]), .raddr(rd_ptr[AW-1:0]), .rdata(rd_data)
  );

  // Decode state.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_dec) begin
      lat_low <= -Half; lat_high <= Half;
      lon_low <= -Half; lon_high <= Half;
      axis_is_lon <= 1'b1;
      chars_seen <= '0;
      error_seen <= StatusOk;
    end else begin
      if (cmd.absorb_step) begin
        if (axis_is_lon) begin
          if (dec_bit) lon_low <= dm_lon; else lon_high <= dm_lon;
        end else begin
          if (dec_bit) lat_low <= dm_lat; else lat_high <= dm_lat;
        end
        axis_is_lon <= ~axis_is_lon;
      end
      if (cmd.absorb_store) chars_seen <= chars_seen + 1'b1;
      if (cmd.set_err && error_seen == StatusOk) error_seen <= cmd.err;
    end
  end

  // Input capture, center, encode engine and output register.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      inr <= in_word;
      bit_idx <= '0;
    end
    if (cmd.absorb_step) bit_idx <= bit_idx + 1'b1;
    if (cmd.calc_center) begin
      clat <= dm_lat;
      clon <= dm_lon;
      hlat <= lat_high - dm_lat;
      hlon <= lon_high - dm_lon;
      rd_ptr <= '0;
    end
    if (cmd.enc_init) begin
      e_lat_lo <= -Half; e_lat_hi <= Half;
      e_lon_lo <= -Half; e_lon_hi <= Half;
      e_on_lon <= 1'b1;
      sym_acc <= '0;
      if (inr.func == FuncEncode) begin
        t_lat <= BW'(inr.latitude_in);
        t_lon <= BW'(inr.longitude_in);
        clat <= '0; clon <= '0; hlat <= '0; hlon <= '0;
      end else begin
        t_lat <= sat(n_lat);
        t_lon <= sat(n_lon);
      end
    end
    if (cmd.enc_step) begin
      if (e_on_lon) begin
        sym_acc <= {sym_acc[3:0], t_lon > em_lon};
        if (t_lon > em_lon) e_lon_lo <= em_lon; else e_lon_hi <= em_lon;
      end else begin
        sym_acc <= {sym_acc[3:0], t_lat > em_lat};
        if (t_lat > em_lat) e_lat_lo <= em_lat; else e_lat_hi <= em_lat;
      end
      e_on_lon <= ~e_on_lon;
    end
    if (cmd.rd_next) rd_ptr <= rd_ptr + 1'b1;
    if (cmd.out_load) begin
      out_word.last_out <= cmd.out_last;
      out_word.center_lat <= 32'(clat);
      out_word.center_lon <= 32'(clon);
      out_word.lat_halfwidth <= 32'(hlat);
      out_word.lon_halfwidth <= 32'(hlon);
      out_word.status <= (inr.func == FuncEncode) ? StatusOk : error_seen;
      if (cmd.out_decode || cmd.out_empty) out_word.hash_char_out <= 8'd0;
      else if (cmd.out_stored) out_word.hash_char_out <= sym_char(rd_data);
      else out_word.hash_char_out <= sym_char(sym_acc);
    end
  end

  always_comb begin
    stat.func = inr.func;
    stat.sym_valid = ~sym[5];
    stat.last_char = inr.last_char_in;
    stat.full = (chars_seen >= CntW'(MaxCh));
    stat.err_free = (error_seen == StatusOk);
    stat.self_dir = inr.neighbor_dir[3];
    stat.chars = chars_seen;
    if (inr.precision == '0) stat.precision = CntW'(1);
    else if (inr.precision > CntW'(MaxCh)) stat.precision = CntW'(MaxCh);
    else stat.precision = inr.precision;
  end
endmodule

FILE: src/gh_ctrl.sv
// Controller of the geohash codec: sequences absorb, encode and emit steps.
// Depends on gh_pkg and the assertion macro header.
`include "geohash_codec_assert.svh"
module gh_ctrl import gh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state, state_next;
  logic [2:0] step, step_next;
  logic [CntW-1:0] emitted, emitted_next, total, total_next;
  logic ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      emitted <= '0;
      total <= '0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      emitted <= emitted_next;
      total <= total_next;
      ov <= ov_next;
    end
  end

  assign out_valid = ov;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    step_next = step;
    emitted_next = emitted;
    total_next = total;
    ov_next = ov && out_stall;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = ST_ABSORB;
          step_next = '0;
        end
      end
      ST_ABSORB: begin
        // Encode skips the decode accumulator; func 3 does nothing.
        if (stat.func == FuncEncode) begin
          total_next = stat.precision;
          emitted_next = '0;
          state_next = ST_SETUP;
        end else if (stat.func != FuncDecode && stat.func != FuncNeighbor) begin
          state_next = ST_IDLE;
        end else if (!stat.sym_valid) begin
          cmd.set_err = 1'b1; cmd.err = StatusBadChar;
          state_next = ST_CENTER;
        end else if (stat.full && step == '0) begin
          cmd.set_err = 1'b1; cmd.err = StatusTooLong;
          state_next = ST_CENTER;
        end else begin
          cmd.absorb_step = 1'b1;
          if (step == '0) cmd.absorb_store = 1'b1;
          step_next = step + 1'b1;
          if (step == 3'd4) state_next = ST_CENTER;
        end
      end
      ST_CENTER: begin
        if (!stat.last_char) begin
          state_next = ST_IDLE;
        end else begin
          cmd.calc_center = 1'b1;
          total_next = stat.chars;
          emitted_next = '0;
          if (stat.func == FuncDecode || stat.chars == '0) state_next = ST_RESULT;
          else if (stat.self_dir) state_next = ST_STORED;
          else state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.enc_init = 1'b1;
        step_next = '0;
        state_next = ST_BISECT;
      end
      ST_BISECT: begin
        cmd.enc_step = 1'b1;
        step_next = step + 1'b1;
        if (step == 3'd4) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov || !out_stall) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (emitted + 1'b1 == total);
          ov_next = 1'b1;
          emitted_next = emitted + 1'b1;
          step_next = '0;
          if (emitted + 1'b1 == total) begin
            cmd.clear_dec = (stat.func != FuncEncode);
            state_next = ST_IDLE;
          end else begin
            state_next = ST_BISECT;
          end
        end
      end
      ST_STORED: begin
        // Wait here while the registered store read fetches the symbol.
        state_next = ST_READ;
      end
      ST_READ: begin
        if (!ov || !out_stall) begin
          cmd.out_load = 1'b1;
          cmd.out_stored = 1'b1;
          cmd.out_last = (emitted + 1'b1 == total);
          cmd.rd_next = 1'b1;
          ov_next = 1'b1;
          emitted_next = emitted + 1'b1;
          if (emitted + 1'b1 == total) begin
            cmd.clear_dec = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_STORED;
          end
        end
      end
      ST_RESULT: begin
        if (!ov || !out_stall) begin
          cmd.out_load = 1'b1;
          cmd.out_decode = (stat.func == FuncDecode);
          cmd.out_empty = (stat.func != FuncDecode);
          cmd.out_last = 1'b1;
          cmd.clear_dec = 1'b1;
          ov_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `GH_ASSERT_IMP(a_no_load_when_held, clk, rst, cmd.out_load, !(ov && out_stall))
  `GH_ASSERT_IMP(a_busy_stalls, clk, rst, state != ST_IDLE, in_stall)
  `GH_ASSERT_NEXT(a_load_shows, clk, rst, cmd.out_load, out_valid)
endmodule

FILE: src/geohash_codec.sv
// Top level of the geohash codec: joins controller and datapath.
// Depends on gh_pkg, gh_ctrl, gh_datapath and gh_ram.
//
// One word is taken at a time. A decode or neighbor character is absorbed
// with one bisection step per cycle over its five bits. Encode and neighbor
// re-encode build each emitted character in the shared bisection unit, up to
// MaxCh characters (twelve by default); the self direction reads the symbol
// store for its characters.
module geohash_codec import gh_pkg::*; #(
  parameter int CoordBits = 32,
  parameter int MaxCh = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);
  cmd_t  cmd;
  stat_t stat;

  gh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  gh_datapath #(.CoordBits(CoordBits), .MaxCh(MaxCh)) u_dp (
    .clk(clk), .rst(rst), .in_word(in_data), .cmd(cmd), .stat(stat),
    .out_word(out_data)
  );
endmodule
